/* sv/tcsf_pkg.sv */
// Shared types, codes and constants of the typed cell spring force unit.
// Used by the front and back sections and the top level.
package tcsf_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int SPACE_DIMS = 2;

  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_REST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd5;

  localparam logic [59:0] RST_STIFFNESS = 60'd270480118382838000;
  localparam logic [59:0] RST_REST      = 60'd288399976088994048;
  localparam logic [31:0] RST_CUTOFF    = 32'd98304;
  localparam logic [16:0] RST_DIV_REST  = 17'd3277;
  localparam logic [31:0] RST_GROWTH    = 32'd65536;
  localparam logic [31:0] RST_TIME_STEP = 32'd546;

  localparam logic [1:0] KIND_EPI  = 2'd0;
  localparam logic [1:0] KIND_MEM  = 2'd1;
  localparam logic [1:0] KIND_STR  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef enum logic [2:0] {
    PAIR_EE   = 3'd0,
    PAIR_MM   = 3'd1,
    PAIR_SS   = 3'd2,
    PAIR_EM   = 3'd3,
    PAIR_MS   = 3'd4,
    PAIR_SE   = 3'd5,
    PAIR_NONE = 3'd6
  } pair_t;

  typedef struct packed {
    logic [59:0] stiffness_pack;
    logic [59:0] rest_length_pack;
    logic [31:0] cutoff;
    logic [16:0] div_rest;
    logic [31:0] growth;
    logic [31:0] time_step;
  } cfg_t;

  // One classified item as it waits between the front and back sections.
  typedef struct packed {
    logic [63:0] sq_x;
    logic [63:0] sq_y;
    logic [31:0] xm;
    logic [31:0] ym;
    logic        xneg;
    logic        yneg;
    logic [9:0]  stiff;
    logic [17:0] rest_base;
    logic        ms_pair;
    logic        grow;
    logic        grow_up;
    logic [49:0] grow_prod;
    logic        unmark;
    logic        dying_a;
    logic [31:0] left_a;
    logic [31:0] span_a;
    logic        dying_b;
    logic [31:0] left_b;
    logic [31:0] span_b;
  } work_t;

  function automatic pair_t pairing(input logic [1:0] a, input logic [1:0] b);
    pair_t p;
    if (a == KIND_NONE || b == KIND_NONE) p = PAIR_NONE;
    else if (a == b) p = pair_t'({1'b0, a});
    else if (a != KIND_STR && b != KIND_STR) p = PAIR_EM;
    else if (a != KIND_EPI && b != KIND_EPI) p = PAIR_MS;
    else p = PAIR_SE;
    return p;
  endfunction

endpackage

/* sv/tcsf_if.sv */
// Valid/ready channel interfaces for cell pairs in and forces out.
// Depends on nothing.
interface tcsf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         type_a;
  logic [1:0]         type_b;
  logic signed [31:0] delta_x;
  logic signed [31:0] delta_y;
  logic [31:0]        age_a;
  logic               spring_marked;
  logic               dying_a;
  logic [31:0]        time_left_a;
  logic [31:0]        apoptosis_span_a;
  logic               dying_b;
  logic [31:0]        time_left_b;
  logic [31:0]        apoptosis_span_b;

  modport source (output valid, type_a, type_b, delta_x, delta_y, age_a, spring_marked,
                  dying_a, time_left_a, apoptosis_span_a, dying_b, time_left_b,
                  apoptosis_span_b, input ready);
  modport sink (input valid, type_a, type_b, delta_x, delta_y, age_a, spring_marked,
                dying_a, time_left_a, apoptosis_span_a, dying_b, time_left_b,
                apoptosis_span_b, output ready);
endinterface

interface tcsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               unmark_spring;
  logic               beyond_cutoff;

  modport source (output valid, force_x, force_y, unmark_spring, beyond_cutoff, input ready);
  modport sink (input valid, force_x, force_y, unmark_spring, beyond_cutoff, output ready);
endinterface

/* sv/tcsf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// The caller supplies the upper remainder, which must be below the divisor.
module tcsf_div #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] bits_q [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  // Dividend bits leave the top of bits while quotient bits enter at the bottom.
  function automatic logic [DW+QW-1:0] step(input logic [DW-1:0] r, input logic [QW-1:0] b,
                                            input logic [DW-1:0] d);
    logic [DW:0]   t;
    logic          qb;
    logic [DW-1:0] rn;
    t  = {r, b[QW-1]};
    qb = (t >= {1'b0, d});
    rn = qb ? DW'(t - {1'b0, d}) : t[DW-1:0];
    return {rn, b[QW-2:0], qb};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QW-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {rem_q[0], bits_q[0]} <= step(rem_in, low_in, den_in);
      den_q[0]  <= den_in;
      side_q[0] <= side_in;
      for (int k = 1; k < QW; k++) begin
        {rem_q[k], bits_q[k]} <= step(rem_q[k-1], bits_q[k-1], den_q[k-1]);
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_out  = vld_q[QW-1];
  assign quo      = bits_q[QW-1];
  assign side_out = side_q[QW-1];

endmodule

/* sv/tcsf_isqrt.sv */
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Thirty-two stages; a side word travels along with each value.
module tcsf_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [63:0]   value,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [31:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int NS = 32;

  logic [33:0]   rem_q  [NS];
  logic [63:0]   val_q  [NS];
  logic [31:0]   root_q [NS];
  logic [SW-1:0] side_q [NS];
  logic [NS-1:0] vld_q;

  function automatic logic [129:0] step(input logic [33:0] r, input logic [63:0] v,
                                        input logic [31:0] q);
    logic [35:0] r2;
    logic [35:0] trial;
    logic [33:0] rn;
    logic [31:0] qn;
    r2    = {r, v[63:62]};
    trial = {2'b00, q, 2'b01};
    if (r2 >= trial) begin
      rn = 34'(r2 - trial);
      qn = {q[30:0], 1'b1};
    end else begin
      rn = r2[33:0];
      qn = {q[30:0], 1'b0};
    end
    return {rn, v[61:0], 2'b00, qn};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {rem_q[0], val_q[0], root_q[0]} <= step('0, value, '0);
      side_q[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        {rem_q[k], val_q[k], root_q[k]} <= step(rem_q[k-1], val_q[k-1], root_q[k-1]);
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_out  = vld_q[NS-1];
  assign root     = root_q[NS-1];
  assign side_out = side_q[NS-1];

endmodule

/* sv/tcsf_front.sv */
// Front section: takes pair items, classifies the pairing, forms squares and
// growth products, and queues the result. Depends on tcsf_pkg and tcsf_if.
module tcsf_front #(
  parameter int DEPTH = tcsf_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  tcsf_in_if.sink         pairs,
  input  tcsf_pkg::cfg_t  cfg,
  output logic            q_valid,
  output tcsf_pkg::work_t q_data,
  input  logic            q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcsf_pkg::work_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  tcsf_pkg::work_t item;
  tcsf_pkg::pair_t pair;
  logic [31:0]     dy;
  logic [17:0]     lam;
  logic [17:0]     diff;
  logic [32:0]     age_sum;
  logic            young;

  always_comb begin
    pair = tcsf_pkg::pairing(pairs.type_a, pairs.type_b);
    dy   = (tcsf_pkg::SPACE_DIMS >= 2) ? pairs.delta_y : '0;

    item.xneg = pairs.delta_x[31];
    item.yneg = dy[31];
    item.xm   = pairs.delta_x[31] ? (~pairs.delta_x + 32'd1) : pairs.delta_x;
    item.ym   = dy[31] ? (~dy + 32'd1) : dy;
    item.sq_x = {32'b0, item.xm} * {32'b0, item.xm};
    item.sq_y = {32'b0, item.ym} * {32'b0, item.ym};

    if (pair == tcsf_pkg::PAIR_NONE) begin
      item.stiff     = '0;
      item.rest_base = '0;
    end else begin
      item.stiff     = cfg.stiffness_pack[10*int'(pair) +: 10];
      item.rest_base = {cfg.rest_length_pack[10*int'(pair) +: 10], 8'b0};
    end
    item.ms_pair = (pair == tcsf_pkg::PAIR_MS);

    // A marked spring grows from the division length toward the pairing length.
    young        = (pairs.age_a < cfg.growth);
    lam          = {1'b0, cfg.div_rest};
    item.grow    = young && pairs.spring_marked;
    item.grow_up = (item.rest_base >= lam);
    diff         = item.grow_up ? (item.rest_base - lam) : (lam - item.rest_base);
    item.grow_prod = {32'b0, diff} * {18'b0, pairs.age_a};
    age_sum      = {1'b0, pairs.age_a} + {1'b0, cfg.time_step};
    item.unmark  = young && (age_sum >= {1'b0, cfg.growth});

    item.dying_a = pairs.dying_a;
    item.left_a  = pairs.time_left_a;
    item.span_a  = pairs.apoptosis_span_a;
    item.dying_b = pairs.dying_b;
    item.left_b  = pairs.time_left_b;
    item.span_b  = pairs.apoptosis_span_b;
  end

  assign pairs.ready = (count != CW'(DEPTH));
  assign push        = pairs.valid && pairs.ready;
  assign q_valid     = (count != '0);
  assign q_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

endmodule

/* sv/tcsf_back.sv */
// Back section: growth division, square root, apoptosis scaling, direction
// division and force products. Depends on tcsf_pkg, tcsf_if, tcsf_div, tcsf_isqrt.
module tcsf_back (
  input  logic            clk,
  input  logic            rst,
  input  tcsf_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  tcsf_pkg::work_t q_data,
  output logic            q_pop,
  tcsf_out_if.source      forces
);

  typedef struct packed {
    logic [63:0] sum;
    logic [9:0]  stiff;
    logic [17:0] rest_base;
    logic        grow;
    logic        grow_up;
    logic        ms_pair;
    logic        unmark;
    logic [31:0] xm;
    logic [31:0] ym;
    logic        xneg;
    logic        yneg;
    logic        dying_a;
    logic [31:0] left_a;
    logic [31:0] span_a;
    logic        dying_b;
    logic [31:0] left_b;
    logic [31:0] span_b;
  } g_side_t;

  typedef struct packed {
    logic [63:0] sum;
    logic [17:0] h;
    logic [49:0] prod_a;
    logic [49:0] prod_b;
    logic [31:0] span_a;
    logic [31:0] span_b;
    logic        dying_a;
    logic        dying_b;
    logic [9:0]  stiff;
    logic        ms_pair;
    logic        unmark;
    logic [31:0] xm;
    logic [31:0] ym;
    logic        xneg;
    logic        yneg;
  } s2_t;

  typedef struct packed {
    logic [17:0] h;
    logic        dying_a;
    logic        dying_b;
    logic [9:0]  stiff;
    logic        ms_pair;
    logic        unmark;
    logic [31:0] xm;
    logic [31:0] ym;
    logic        xneg;
    logic        yneg;
  } sq_side_t;

  typedef struct packed {
    logic        zero;
    logic        sat;
  } h_side_t;

  typedef struct packed {
    logic [31:0] dlen;
    logic [32:0] cmag;
    logic        cneg;
    logic        cut;
    logic [9:0]  stiff;
    logic        unmark;
    logic [31:0] xm;
    logic [31:0] ym;
    logic        xneg;
    logic        yneg;
  } s4_t;

  typedef struct packed {
    logic [42:0] p;
    logic        fz;
    logic        xz;
    logic        xneg;
    logic        cneg;
    logic        cut;
    logic        unmark;
  } ux_side_t;

  typedef struct packed {
    logic        yz;
    logic        yneg;
  } uy_side_t;

  typedef struct packed {
    logic [58:0] mxh;
    logic [57:0] mxl;
    logic [58:0] myh;
    logic [57:0] myl;
    logic        zx;
    logic        zy;
    logic        negx;
    logic        negy;
    logic        cut;
    logic        unmark;
  } s6_t;

  logic     en;
  g_side_t  g_in, g_out;
  logic     g_vld;
  logic [17:0] g_quo;
  s2_t      s2_d, s2;
  logic     s2_vld;
  sq_side_t sq_in, sq_out;
  logic     sq_vld;
  logic [31:0] dlen;
  h_side_t  ha_in, ha_out, hb_in, hb_out;
  logic [31:0] qa, qb;
  logic [31:0] ra0, rb0;
  s4_t      s4_d, s4;
  logic     s4_vld;
  logic [31:0] half_a, half_b;
  logic [32:0] tot;
  ux_side_t ux_in, ux_out;
  uy_side_t uy_in, uy_out;
  logic     u_vld;
  logic [30:0] ux, uy;
  s6_t      s6_d, s6;
  logic     s6_vld;
  logic [59:0] sum_x, sum_y;

  function automatic logic [31:0] to_force(input logic [40:0] mag, input logic neg,
                                           input logic zero);
    logic [40:0] m;
    logic [31:0] r;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      m = (mag > 41'h080000000) ? 41'h080000000 : mag;
      r = 32'(~m + 41'd1);
    end else begin
      r = (mag > 41'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return r;
  endfunction

  // The whole section moves as one; it halts only while a result waits.
  assign en    = !forces.valid || forces.ready;
  assign q_pop = en && q_valid;

  always_comb begin
    g_in.sum       = q_data.sq_x + q_data.sq_y;
    g_in.stiff     = q_data.stiff;
    g_in.rest_base = q_data.rest_base;
    g_in.grow      = q_data.grow;
    g_in.grow_up   = q_data.grow_up;
    g_in.ms_pair   = q_data.ms_pair;
    g_in.unmark    = q_data.unmark;
    g_in.xm        = q_data.xm;
    g_in.ym        = q_data.ym;
    g_in.xneg      = q_data.xneg;
    g_in.yneg      = q_data.yneg;
    g_in.dying_a   = q_data.dying_a;
    g_in.left_a    = q_data.left_a;
    g_in.span_a    = q_data.span_a;
    g_in.dying_b   = q_data.dying_b;
    g_in.left_b    = q_data.left_b;
    g_in.span_b    = q_data.span_b;
  end

  tcsf_div #(.DW(32), .QW(18), .SW($bits(g_side_t))) u_grow_div (
    .clk(clk), .rst(rst), .en(en), .vld_in(q_valid),
    .rem_in(q_data.grow ? q_data.grow_prod[49:18] : 32'b0),
    .low_in(q_data.grow ? q_data.grow_prod[17:0] : 18'b0),
    .den_in(cfg.growth), .side_in(g_in),
    .vld_out(g_vld), .quo(g_quo), .side_out(g_out)
  );

  always_comb begin
    logic [18:0] lam;
    logic [18:0] rest;
    lam  = {2'b0, cfg.div_rest};
    if (!g_out.grow) rest = {1'b0, g_out.rest_base};
    else if (g_out.grow_up) rest = lam + {1'b0, g_quo};
    else rest = lam - {1'b0, g_quo};
    s2_d.sum     = g_out.sum;
    s2_d.h       = rest[18:1];
    s2_d.prod_a  = {32'b0, rest[18:1]} * {18'b0, g_out.left_a};
    s2_d.prod_b  = {32'b0, rest[18:1]} * {18'b0, g_out.left_b};
    s2_d.span_a  = g_out.span_a;
    s2_d.span_b  = g_out.span_b;
    s2_d.dying_a = g_out.dying_a;
    s2_d.dying_b = g_out.dying_b;
    s2_d.stiff   = g_out.stiff;
    s2_d.ms_pair = g_out.ms_pair;
    s2_d.unmark  = g_out.unmark;
    s2_d.xm      = g_out.xm;
    s2_d.ym      = g_out.ym;
    s2_d.xneg    = g_out.xneg;
    s2_d.yneg    = g_out.yneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_d;
    end
  end

  // A scaled half length that would not fit in 32 bits saturates.
  always_comb begin
    ha_in.zero = (s2.span_a == '0);
    ha_in.sat  = ({14'b0, s2.prod_a[49:32]} >= s2.span_a);
    hb_in.zero = (s2.span_b == '0);
    hb_in.sat  = ({14'b0, s2.prod_b[49:32]} >= s2.span_b);
    ra0 = (ha_in.zero || ha_in.sat) ? 32'b0 : {14'b0, s2.prod_a[49:32]};
    rb0 = (hb_in.zero || hb_in.sat) ? 32'b0 : {14'b0, s2.prod_b[49:32]};
    sq_in.h       = s2.h;
    sq_in.dying_a = s2.dying_a;
    sq_in.dying_b = s2.dying_b;
    sq_in.stiff   = s2.stiff;
    sq_in.ms_pair = s2.ms_pair;
    sq_in.unmark  = s2.unmark;
    sq_in.xm      = s2.xm;
    sq_in.ym      = s2.ym;
    sq_in.xneg    = s2.xneg;
    sq_in.yneg    = s2.yneg;
  end

  tcsf_isqrt #(.SW($bits(sq_side_t))) u_dist (
    .clk(clk), .rst(rst), .en(en), .vld_in(s2_vld), .value(s2.sum), .side_in(sq_in),
    .vld_out(sq_vld), .root(dlen), .side_out(sq_out)
  );

  tcsf_div #(.DW(32), .QW(32), .SW($bits(h_side_t))) u_half_a (
    .clk(clk), .rst(rst), .en(en), .vld_in(s2_vld),
    .rem_in(ra0), .low_in(s2.prod_a[31:0]), .den_in(s2.span_a), .side_in(ha_in),
    .vld_out(), .quo(qa), .side_out(ha_out)
  );

  tcsf_div #(.DW(32), .QW(32), .SW($bits(h_side_t))) u_half_b (
    .clk(clk), .rst(rst), .en(en), .vld_in(s2_vld),
    .rem_in(rb0), .low_in(s2.prod_b[31:0]), .den_in(s2.span_b), .side_in(hb_in),
    .vld_out(), .quo(qb), .side_out(hb_out)
  );

  always_comb begin
    if (!sq_out.dying_a) half_a = {14'b0, sq_out.h};
    else if (ha_out.zero) half_a = '0;
    else if (ha_out.sat) half_a = '1;
    else half_a = qa;
    if (!sq_out.dying_b) half_b = {14'b0, sq_out.h};
    else if (hb_out.zero) half_b = '0;
    else if (hb_out.sat) half_b = '1;
    else half_b = qb;
    tot         = {1'b0, half_a} + {1'b0, half_b};
    s4_d.dlen   = dlen;
    s4_d.cneg   = (tot > {1'b0, dlen});
    s4_d.cmag   = s4_d.cneg ? (tot - {1'b0, dlen}) : ({1'b0, dlen} - tot);
    s4_d.cut    = sq_out.ms_pair && (dlen >= cfg.cutoff);
    s4_d.stiff  = sq_out.stiff;
    s4_d.unmark = sq_out.unmark;
    s4_d.xm     = sq_out.xm;
    s4_d.ym     = sq_out.ym;
    s4_d.xneg   = sq_out.xneg;
    s4_d.yneg   = sq_out.yneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= s4_d;
    end
  end

  // Unit direction is |delta| * 2^30 / length; the component never exceeds the length.
  always_comb begin
    ux_in.p      = {33'b0, s4.stiff} * {10'b0, s4.cmag};
    ux_in.fz     = (s4.dlen == '0) || (s4.stiff == '0) || (s4.cmag == '0) || s4.cut;
    ux_in.xz     = (s4.xm == '0);
    ux_in.xneg   = s4.xneg;
    ux_in.cneg   = s4.cneg;
    ux_in.cut    = s4.cut;
    ux_in.unmark = s4.unmark;
    uy_in.yz     = (s4.ym == '0);
    uy_in.yneg   = s4.yneg;
  end

  tcsf_div #(.DW(32), .QW(31), .SW($bits(ux_side_t))) u_dir_x (
    .clk(clk), .rst(rst), .en(en), .vld_in(s4_vld),
    .rem_in((s4.dlen == '0) ? 32'b0 : {1'b0, s4.xm[31:1]}),
    .low_in({s4.xm[0], 30'b0}), .den_in(s4.dlen), .side_in(ux_in),
    .vld_out(u_vld), .quo(ux), .side_out(ux_out)
  );

  tcsf_div #(.DW(32), .QW(31), .SW($bits(uy_side_t))) u_dir_y (
    .clk(clk), .rst(rst), .en(en), .vld_in(s4_vld),
    .rem_in((s4.dlen == '0) ? 32'b0 : {1'b0, s4.ym[31:1]}),
    .low_in({s4.ym[0], 30'b0}), .den_in(s4.dlen), .side_in(uy_in),
    .vld_out(), .quo(uy), .side_out(uy_out)
  );

  always_comb begin
    s6_d.mxh    = {16'b0, ux_out.p} * {43'b0, ux[30:15]};
    s6_d.mxl    = {15'b0, ux_out.p} * {43'b0, ux[14:0]};
    s6_d.myh    = {16'b0, ux_out.p} * {43'b0, uy[30:15]};
    s6_d.myl    = {15'b0, ux_out.p} * {43'b0, uy[14:0]};
    s6_d.zx     = ux_out.fz || ux_out.xz;
    s6_d.zy     = ux_out.fz || uy_out.yz;
    s6_d.negx   = ux_out.cneg ^ ux_out.xneg;
    s6_d.negy   = ux_out.cneg ^ uy_out.yneg;
    s6_d.cut    = ux_out.cut;
    s6_d.unmark = ux_out.unmark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= u_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6 <= s6_d;
    end
  end

  assign sum_x = {1'b0, s6.mxh} + {17'b0, s6.mxl[57:15]};
  assign sum_y = {1'b0, s6.myh} + {17'b0, s6.myl[57:15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      forces.valid <= 1'b0;
    end else if (en) begin
      forces.valid <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      forces.force_x       <= to_force(sum_x[59:19], s6.negx, s6.zx);
      forces.force_y       <= to_force(sum_y[59:19], s6.negy, s6.zy);
      forces.unmark_spring <= s6.unmark && !s6.cut;
      forces.beyond_cutoff <= s6.cut;
    end
  end

endmodule

/* sv/typed_cell_spring_force_unit.sv */
// Top level of the typed cell spring force unit: configuration registers,
// front section and back section. Depends on tcsf_pkg, tcsf_if, tcsf_front, tcsf_back.
//
//   channel   kind          direction  carries
//   pairs     valid/ready   in         one cell pair per item
//   forces    valid/ready   out        force on cell A and two flags per item
//   cfg       write only    in         register index and data
//
// One item is taken per clock cycle, sustained while the output is not stalled. A result
// passes through the growth divider, the square root, the direction divider and the
// product stages in series. Reset is synchronous and clears the queue, all valid bits
// and the registers to their defaults. A stalled output freezes the back section; the
// queue in front keeps taking items until full.
module typed_cell_spring_force_unit #(
  parameter int FIFO_DEPTH = tcsf_pkg::FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  tcsf_in_if.sink                        pairs,
  tcsf_out_if.source                     forces,
  input  logic                           cfg_write,
  input  logic [tcsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcsf_pkg::CFG_W-1:0]     cfg_data
);

  tcsf_pkg::cfg_t  cfg;
  logic            q_valid;
  logic            q_pop;
  tcsf_pkg::work_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stiffness_pack   <= tcsf_pkg::RST_STIFFNESS;
      cfg.rest_length_pack <= tcsf_pkg::RST_REST;
      cfg.cutoff           <= tcsf_pkg::RST_CUTOFF;
      cfg.div_rest         <= tcsf_pkg::RST_DIV_REST;
      cfg.growth           <= tcsf_pkg::RST_GROWTH;
      cfg.time_step        <= tcsf_pkg::RST_TIME_STEP;
    end else if (cfg_write) begin
      case (cfg_index)
        tcsf_pkg::CFG_STIFFNESS: cfg.stiffness_pack   <= cfg_data[59:0];
        tcsf_pkg::CFG_REST:      cfg.rest_length_pack <= cfg_data[59:0];
        tcsf_pkg::CFG_CUTOFF:    cfg.cutoff           <= cfg_data[31:0];
        tcsf_pkg::CFG_DIV_REST:  cfg.div_rest         <= cfg_data[16:0];
        tcsf_pkg::CFG_GROWTH:    cfg.growth           <= cfg_data[31:0];
        tcsf_pkg::CFG_TIME_STEP: cfg.time_step        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  tcsf_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk(clk), .rst(rst), .pairs(pairs), .cfg(cfg),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  tcsf_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .forces(forces)
  );

endmodule
